@@ src/rfkr_pkg.sv @@
`timescale 1ns / 1ps

package rfkr_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_W         = 16;
    localparam int ID_W          = 16;
    localparam int POS_W         = 7;
    localparam int CAP_W         = 7;
    localparam int CAP_RESET     = 64;

    typedef enum logic [2:0] {
        ACT_ENQUEUE = 3'd0,
        ACT_DEQUEUE = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_FIND    = 3'd3,
        ACT_EXPAND  = 3'd4,
        ACT_CLEAR   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK             = 3'd0,
        STAT_FULL           = 3'd1,
        STAT_EMPTY          = 3'd2,
        STAT_NOT_FOUND      = 3'd3,
        STAT_NOT_EXPANDABLE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } state_t;

    typedef enum logic {
        CFG_INITIAL = 1'b0,
        CFG_MAXIMUM = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             capture;
        logic             is_remove;
        logic             is_find;
        logic             load;
        logic             shift_all;
        logic             shift_hit;
        logic [KEY_W-1:0] cmp_key;
        logic [KEY_W-1:0] new_key;
        logic [ID_W-1:0]  new_id;
    } cell_ctl_t;

endpackage

@@ src/rfkr_cell.sv @@
`timescale 1ns / 1ps

module rfkr_cell #(
    parameter int DEPTH = rfkr_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfkr_pkg::cell_ctl_t           ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic [rfkr_pkg::POS_W-1:0]    position,
    input  logic [rfkr_pkg::KEY_W-1:0]    next_key,
    input  logic [rfkr_pkg::ID_W-1:0]     next_id,
    input  logic                          hit_in,
    input  logic [rfkr_pkg::KEY_W-1:0]    sel_key_in,
    input  logic [rfkr_pkg::ID_W-1:0]     sel_id_in,
    output logic [rfkr_pkg::KEY_W-1:0]    key,
    output logic [rfkr_pkg::ID_W-1:0]     id,
    output logic                          hit_out,
    output logic [rfkr_pkg::KEY_W-1:0]    sel_key_out,
    output logic [rfkr_pkg::ID_W-1:0]     sel_id_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > rfkr_pkg::POS_W) ? CNT_W : rfkr_pkg::POS_W;
    localparam logic [CNT_W-1:0] IDX     = CNT_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_POS = CMP_W'(INDEX + 1);

    logic [rfkr_pkg::KEY_W-1:0] key_reg, key_next;
    logic [rfkr_pkg::ID_W-1:0]  id_reg, id_next;
    logic                       hit_reg, hit_next;
    logic                       in_range;
    logic                       hit_now;
    logic                       shift;
    logic                       sel;

    always_comb
    begin
        in_range = IDX < count;
        hit_now  = in_range
                 & ((ctl.is_remove & (ctl.cmp_key == key_reg))
                 |  (ctl.is_find & (CMP_W'(position) == IDX_POS)));
        hit_next = ctl.capture ? hit_now : hit_reg;
        hit_out  = hit_in | hit_reg;
        shift    = ctl.shift_all | (ctl.shift_hit & hit_out);
        sel      = hit_reg & ~hit_in;

        key_next = key_reg;
        id_next  = id_reg;
        if (ctl.load && (IDX == count))
        begin
            key_next = ctl.new_key;
            id_next  = ctl.new_id;
        end
        else if (shift)
        begin
            key_next = next_key;
            id_next  = next_id;
        end

        sel_key_out = sel_key_in | (sel ? key_reg : '0);
        sel_id_out  = sel_id_in | (sel ? id_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

@@ src/request_fifo_keyed_removal.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    action, request_key, request_id, position
// output    out        out_valid / out_stall  status, released, entry_key, entry_id,
//                                             occupancy, capacity_now, last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request first registers the key and position compares of every cell; then, once the
// output is free, one shift of the cell chain with the result loaded into the output register.
// Clear then gives one result per cycle while the output is not stalled, one per held entry.
// rst_n empties the queue; capacity resets to 64 (DEPTH if less), the maximum to 64.
// Requests are taken one at a time; a stalled result holds the chain until taken.

module request_fifo_keyed_removal #(
    parameter int DEPTH = rfkr_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    action,
    input  logic [rfkr_pkg::KEY_W-1:0]    request_key,
    input  logic [rfkr_pkg::ID_W-1:0]     request_id,
    input  logic [rfkr_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic                          released,
    output logic [rfkr_pkg::KEY_W-1:0]    entry_key,
    output logic [rfkr_pkg::ID_W-1:0]     entry_id,
    output logic [rfkr_pkg::CAP_W-1:0]    occupancy,
    output logic [rfkr_pkg::CAP_W-1:0]    capacity_now,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [rfkr_pkg::CAP_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > rfkr_pkg::CAP_W) ? CNT_W : rfkr_pkg::CAP_W;
    localparam logic [rfkr_pkg::CAP_W-1:0] CAP_RESET_EFF =
        rfkr_pkg::CAP_W'((rfkr_pkg::CAP_RESET > DEPTH) ? DEPTH : rfkr_pkg::CAP_RESET);

    function automatic logic [rfkr_pkg::CAP_W-1:0] clamp_cap(
        input logic [rfkr_pkg::CAP_W-1:0] v
    );
        if (v == '0)
            return rfkr_pkg::CAP_W'(1);
        else if (int'(v) > DEPTH)
            return rfkr_pkg::CAP_W'(DEPTH);
        else
            return v;
    endfunction

    rfkr_pkg::state_t               state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [rfkr_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic [rfkr_pkg::CAP_W-1:0]     max_cap_reg, max_cap_next;
    logic [2:0]                     act_reg, act_next;
    logic [rfkr_pkg::KEY_W-1:0]     req_key_reg, req_key_next;
    logic [rfkr_pkg::ID_W-1:0]      req_id_reg, req_id_next;

    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     status_reg, status_next;
    logic                           released_reg, released_next;
    logic [rfkr_pkg::KEY_W-1:0]     entry_key_reg, entry_key_next;
    logic [rfkr_pkg::ID_W-1:0]      entry_id_reg, entry_id_next;
    logic [rfkr_pkg::CAP_W-1:0]     occupancy_reg, occupancy_next;
    logic [rfkr_pkg::CAP_W-1:0]     capacity_reg, capacity_next;
    logic                           last_reg, last_next;

    rfkr_pkg::cell_ctl_t            ctl;
    logic [rfkr_pkg::KEY_W-1:0]     key_arr [0:DEPTH];
    logic [rfkr_pkg::ID_W-1:0]      id_arr [0:DEPTH];
    logic                           hit_chain [0:DEPTH];
    logic [rfkr_pkg::KEY_W-1:0]     sel_key_chain [0:DEPTH];
    logic [rfkr_pkg::ID_W-1:0]      sel_id_chain [0:DEPTH];

    logic                           out_free;
    logic                           emit;
    logic [2:0]                     emit_status;
    logic                           emit_released;
    logic [rfkr_pkg::KEY_W-1:0]     emit_key;
    logic [rfkr_pkg::ID_W-1:0]      emit_id;
    logic                           emit_last;
    logic [rfkr_pkg::CAP_W-1:0]     eff_max;
    logic                           found;

    assign key_arr[DEPTH]       = '0;
    assign id_arr[DEPTH]        = '0;
    assign hit_chain[0]         = 1'b0;
    assign sel_key_chain[0]     = '0;
    assign sel_id_chain[0]      = '0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        rfkr_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .count       (count_reg),
            .position    (position),
            .next_key    (key_arr[g+1]),
            .next_id     (id_arr[g+1]),
            .hit_in      (hit_chain[g]),
            .sel_key_in  (sel_key_chain[g]),
            .sel_id_in   (sel_id_chain[g]),
            .key         (key_arr[g]),
            .id          (id_arr[g]),
            .hit_out     (hit_chain[g+1]),
            .sel_key_out (sel_key_chain[g+1]),
            .sel_id_out  (sel_id_chain[g+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        max_cap_next   = max_cap_reg;
        act_next       = act_reg;
        req_key_next   = req_key_reg;
        req_id_next    = req_id_reg;

        out_free       = !out_valid_reg || !out_stall;
        eff_max        = clamp_cap(max_cap_reg);
        found          = hit_chain[DEPTH];
        in_stall       = state_reg != rfkr_pkg::S_IDLE;

        ctl            = '0;
        ctl.cmp_key    = request_key;
        ctl.new_key    = req_key_reg;
        ctl.new_id     = req_id_reg;

        emit           = 1'b0;
        emit_status    = rfkr_pkg::STAT_OK;
        emit_released  = 1'b0;
        emit_key       = '0;
        emit_id        = '0;
        emit_last      = 1'b1;

        unique case (state_reg)
            rfkr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture   = 1'b1;
                    ctl.is_remove = action == rfkr_pkg::ACT_REMOVE;
                    ctl.is_find   = action == rfkr_pkg::ACT_FIND;
                    act_next      = action;
                    req_key_next  = request_key;
                    req_id_next   = request_id;
                    state_next    = rfkr_pkg::S_EXEC;
                end
            end
            rfkr_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = rfkr_pkg::S_IDLE;
                    unique case (act_reg)
                        rfkr_pkg::ACT_ENQUEUE:
                        begin
                            emit_key = req_key_reg;
                            emit_id  = req_id_reg;
                            if (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                            begin
                                emit_status = rfkr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        rfkr_pkg::ACT_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_status = rfkr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                emit_released = 1'b1;
                                emit_key      = key_arr[0];
                                emit_id       = id_arr[0];
                                ctl.shift_all = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        rfkr_pkg::ACT_REMOVE:
                        begin
                            if (found)
                            begin
                                emit_released = 1'b1;
                                emit_key      = req_key_reg;
                                emit_id       = sel_id_chain[DEPTH];
                                ctl.shift_hit = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                emit_status = rfkr_pkg::STAT_NOT_FOUND;
                            end
                        end
                        rfkr_pkg::ACT_FIND:
                        begin
                            if (found)
                            begin
                                emit_key = sel_key_chain[DEPTH];
                                emit_id  = sel_id_chain[DEPTH];
                            end
                            else
                            begin
                                emit_status = rfkr_pkg::STAT_NOT_FOUND;
                            end
                        end
                        rfkr_pkg::ACT_EXPAND:
                        begin
                            if (cap_reg < eff_max)
                            begin
                                cap_next = cap_reg + rfkr_pkg::CAP_W'(1);
                            end
                            else
                            begin
                                emit_status = rfkr_pkg::STAT_NOT_EXPANDABLE;
                            end
                        end
                        rfkr_pkg::ACT_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_status = rfkr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                emit       = 1'b0;
                                state_next = rfkr_pkg::S_CLEAR;
                            end
                        end
                        default:
                        begin
                            emit_status = rfkr_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            rfkr_pkg::S_CLEAR:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    emit_released = 1'b1;
                    emit_key      = key_arr[0];
                    emit_id       = id_arr[0];
                    emit_last     = count_reg == CNT_W'(1);
                    ctl.shift_all = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (emit_last)
                    begin
                        state_next = rfkr_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rfkr_pkg::S_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block itself does not enforce it
        if (cfg_valid)
        begin
            if (cfg_index == rfkr_pkg::CFG_INITIAL)
            begin
                cap_next      = (clamp_cap(cfg_data) > eff_max) ? eff_max
                                                                : clamp_cap(cfg_data);
            end
            else
            begin
                max_cap_next = cfg_data;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        released_next  = released_reg;
        entry_key_next = entry_key_reg;
        entry_id_next  = entry_id_reg;
        occupancy_next = occupancy_reg;
        capacity_next  = capacity_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = emit_status;
            released_next  = emit_released;
            entry_key_next = emit_key;
            entry_id_next  = emit_id;
            occupancy_next = rfkr_pkg::CAP_W'(count_next);
            capacity_next  = cap_next;
            last_next      = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfkr_pkg::S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET_EFF;
            max_cap_reg   <= rfkr_pkg::CAP_W'(rfkr_pkg::CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            max_cap_reg   <= max_cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        req_key_reg   <= req_key_next;
        req_id_reg    <= req_id_next;
        status_reg    <= status_next;
        released_reg  <= released_next;
        entry_key_reg <= entry_key_next;
        entry_id_reg  <= entry_id_next;
        occupancy_reg <= occupancy_next;
        capacity_reg  <= capacity_next;
        last_reg      <= last_next;
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign released     = released_reg;
    assign entry_key    = entry_key_reg;
    assign entry_id     = entry_id_reg;
    assign occupancy    = occupancy_reg;
    assign capacity_now = capacity_reg;
    assign last         = last_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int QDEPTH    = rfkr_pkg::DEPTH_DEFAULT;
    localparam int SETTLE    = 4;
    localparam int LONG_HOLD = 300;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]                 status;
        logic                       released;
        logic [rfkr_pkg::KEY_W-1:0] key;
        logic [rfkr_pkg::ID_W-1:0]  id;
        logic [rfkr_pkg::CAP_W-1:0] occupancy;
        logic [rfkr_pkg::CAP_W-1:0] capacity;
        logic                       last;
    } queue_result_t;

    class request_ledger;
        logic [rfkr_pkg::KEY_W-1:0] held_keys[$];
        logic [rfkr_pkg::ID_W-1:0]  held_ids[$];
        logic [rfkr_pkg::CAP_W-1:0] initial_reg;
        logic [rfkr_pkg::CAP_W-1:0] maximum_reg;
        int unsigned                live_cap;
        queue_result_t              due_results[$];
        int unsigned                requests_seen;
        int unsigned                results_seen;
        int unsigned                mismatches;
        int unsigned                full_refusals;
        int unsigned                keyed_hits;
        int unsigned                clear_runs;

        function int unsigned clamp_cap(logic [rfkr_pkg::CAP_W-1:0] v);
            if (v < 1) return 1;
            if (v > QDEPTH) return QDEPTH;
            return v;
        endfunction

        function int unsigned initial_cap();
            int unsigned v;
            int unsigned m;
            v = clamp_cap(initial_reg);
            m = clamp_cap(maximum_reg);
            return (v > m) ? m : v;
        endfunction

        function void reset_state();
            held_keys.delete();
            held_ids.delete();
            initial_reg = rfkr_pkg::CAP_W'(rfkr_pkg::CAP_RESET);
            maximum_reg = rfkr_pkg::CAP_W'(rfkr_pkg::CAP_RESET);
            live_cap = initial_cap();
        endfunction

        function void write_register(rfkr_pkg::cfg_index_t idx,
                                     logic [rfkr_pkg::CAP_W-1:0] value);
            if (idx == rfkr_pkg::CFG_INITIAL)
            begin
                initial_reg = value;
                live_cap = initial_cap();
            end
            else
            begin
                maximum_reg = value;
            end
        endfunction

        function void due(rfkr_pkg::status_t st, logic rel, logic [rfkr_pkg::KEY_W-1:0] key,
                          logic [rfkr_pkg::ID_W-1:0] id, logic fin);
            queue_result_t r;
            r.status = st;
            r.released = rel;
            r.key = key;
            r.id = id;
            r.occupancy = rfkr_pkg::CAP_W'(held_keys.size());
            r.capacity = rfkr_pkg::CAP_W'(live_cap);
            r.last = fin;
            due_results.push_back(r);
        endfunction

        function void note_request(logic [2:0] act, logic [rfkr_pkg::KEY_W-1:0] key,
                                   logic [rfkr_pkg::ID_W-1:0] id,
                                   logic [rfkr_pkg::POS_W-1:0] pos);
            int hit;
            int n;
            logic [rfkr_pkg::KEY_W-1:0] k;
            logic [rfkr_pkg::ID_W-1:0] d;
            requests_seen++;
            n = held_keys.size();
            case (act)
                rfkr_pkg::ACT_ENQUEUE:
                begin
                    if (n >= live_cap || n >= QDEPTH)
                    begin
                        full_refusals++;
                        due(rfkr_pkg::STAT_FULL, 1'b0, key, id, 1'b1);
                    end
                    else
                    begin
                        held_keys.push_back(key);
                        held_ids.push_back(id);
                        due(rfkr_pkg::STAT_OK, 1'b0, key, id, 1'b1);
                    end
                end
                rfkr_pkg::ACT_DEQUEUE:
                begin
                    if (n == 0)
                    begin
                        due(rfkr_pkg::STAT_EMPTY, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        k = held_keys.pop_front();
                        d = held_ids.pop_front();
                        due(rfkr_pkg::STAT_OK, 1'b1, k, d, 1'b1);
                    end
                end
                rfkr_pkg::ACT_REMOVE:
                begin
                    hit = -1;
                    for (int i = 0; i < n; i++)
                    begin
                        if (hit < 0 && held_keys[i] == key) hit = i;
                    end
                    if (hit >= 0)
                    begin
                        d = held_ids[hit];
                        held_keys.delete(hit);
                        held_ids.delete(hit);
                        keyed_hits++;
                        due(rfkr_pkg::STAT_OK, 1'b1, key, d, 1'b1);
                    end
                    else
                    begin
                        due(rfkr_pkg::STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                    end
                end
                rfkr_pkg::ACT_FIND:
                begin
                    if (pos >= 1 && pos <= n)
                    begin
                        due(rfkr_pkg::STAT_OK, 1'b0, held_keys[pos-1], held_ids[pos-1], 1'b1);
                    end
                    else
                    begin
                        due(rfkr_pkg::STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                    end
                end
                rfkr_pkg::ACT_EXPAND:
                begin
                    if (live_cap < clamp_cap(maximum_reg))
                    begin
                        live_cap++;
                        due(rfkr_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        due(rfkr_pkg::STAT_NOT_EXPANDABLE, 1'b0, '0, '0, 1'b1);
                    end
                end
                rfkr_pkg::ACT_CLEAR:
                begin
                    if (n == 0)
                    begin
                        due(rfkr_pkg::STAT_EMPTY, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        clear_runs++;
                        for (int i = 0; i < n; i++)
                        begin
                            k = held_keys.pop_front();
                            d = held_ids.pop_front();
                            due(rfkr_pkg::STAT_OK, 1'b1, k, d, i == n - 1);
                        end
                    end
                end
                default: due(rfkr_pkg::STAT_OK, 1'b0, '0, '0, 1'b1);
            endcase
        endfunction

        function string show(queue_result_t r);
            return $sformatf("status=%0d released=%0d key=%h id=%h occ=%0d cap=%0d last=%0d",
                             r.status, r.released, r.key, r.id, r.occupancy,
                             r.capacity, r.last);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            logic bad;
            results_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = due_results.pop_front();
            bad = (got.status !== want.status) || (got.released !== want.released)
                || (got.key !== want.key) || (got.id !== want.id)
                || (got.occupancy !== want.occupancy) || (got.capacity !== want.capacity)
                || (got.last !== want.last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [2:0]                 action = '0;
    logic [rfkr_pkg::KEY_W-1:0] request_key = '0;
    logic [rfkr_pkg::ID_W-1:0]  request_id = '0;
    logic [rfkr_pkg::POS_W-1:0] position = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [2:0]                 status;
    logic                       released;
    logic [rfkr_pkg::KEY_W-1:0] entry_key;
    logic [rfkr_pkg::ID_W-1:0]  entry_id;
    logic [rfkr_pkg::CAP_W-1:0] occupancy;
    logic [rfkr_pkg::CAP_W-1:0] capacity_now;
    logic                       last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_index = 1'b0;
    logic [rfkr_pkg::CAP_W-1:0] cfg_data = '0;

    request_ledger ledger;
    logic          calm = 1'b0;
    logic          long_hold_done = 1'b0;
    int unsigned   cfg_writes = 0;

    request_fifo_keyed_removal #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .request_key(request_key),
        .request_id(request_id),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .released(released),
        .entry_key(entry_key),
        .entry_id(entry_id),
        .occupancy(occupancy),
        .capacity_now(capacity_now),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rfkr_pkg::KEY_W-1:0] pooled_key();
        if ($urandom_range(0, 1) != 0) return rfkr_pkg::KEY_W'($urandom_range(0, 7));
        return rfkr_pkg::KEY_W'($urandom);
    endfunction

    task automatic send_request(input logic [2:0] act,
                                input logic [rfkr_pkg::KEY_W-1:0] key,
                                input logic [rfkr_pkg::ID_W-1:0] id,
                                input logic [rfkr_pkg::POS_W-1:0] pos);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        request_key <= key;
        request_id <= id;
        position <= pos;
        // hold the request until taken
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.note_request(act, key, id, pos);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input rfkr_pkg::cfg_index_t idx,
                                  input logic [rfkr_pkg::CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ledger.write_register(idx, value);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(input int count, input int enq_pct, input int exp_pct,
                              input int clr_pct);
        int r;
        int s;
        int n;
        logic [2:0]                 act;
        logic [rfkr_pkg::KEY_W-1:0] key;
        logic [rfkr_pkg::ID_W-1:0]  id;
        logic [rfkr_pkg::POS_W-1:0] pos;
        repeat (count)
        begin
            n = ledger.held_keys.size();
            key = pooled_key();
            id = rfkr_pkg::ID_W'($urandom);
            pos = rfkr_pkg::POS_W'($urandom_range(0, 127));
            r = $urandom_range(0, 99);
            if (r < enq_pct)
                act = rfkr_pkg::ACT_ENQUEUE;
            else if (r < enq_pct + exp_pct)
                act = rfkr_pkg::ACT_EXPAND;
            else if (r < enq_pct + exp_pct + clr_pct)
                act = rfkr_pkg::ACT_CLEAR;
            else
            begin
                s = $urandom_range(0, 19);
                if (s == 0)
                    act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
                else if (s < 7)
                    act = rfkr_pkg::ACT_DEQUEUE;
                else if (s < 14)
                    act = rfkr_pkg::ACT_REMOVE;
                else
                    act = rfkr_pkg::ACT_FIND;
            end
            if (act == rfkr_pkg::ACT_REMOVE && n > 0 && $urandom_range(0, 9) < 6)
                key = ledger.held_keys[$urandom_range(0, n - 1)];
            if (act == rfkr_pkg::ACT_FIND && n > 0 && $urandom_range(0, 9) < 7)
                pos = rfkr_pkg::POS_W'($urandom_range(1, n));
            send_request(act, key, id, pos);
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.released = released;
            got.key = entry_key;
            got.id = entry_id;
            got.occupancy = occupancy;
            got.capacity = capacity_now;
            got.last = last;
            ledger.check_result(got);
        end
    end

    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && ledger.results_seen >= 30)
            begin
                // hold off long enough for the sender to back up
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                len = idle_length();
                if (len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (len) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int waited;
        int n;
        ledger = new();
        ledger.reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(rfkr_pkg::ACT_DEQUEUE, 16'h1234, 16'h0001, 7'd0);
        send_request(rfkr_pkg::ACT_REMOVE, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 7'd127);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_EXPAND, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'h0000, 16'hFFFF, 7'd0);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'hFFFF, 16'h0000, 7'd127);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'h0005, 16'h0001, 7'd64);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'h0005, 16'h0002, 7'd1);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd1);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd4);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd5);
        send_request(rfkr_pkg::ACT_FIND, 16'hFFFF, 16'hFFFF, 7'd127);
        send_request(rfkr_pkg::ACT_REMOVE, 16'h0005, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_REMOVE, 16'h1234, 16'h0000, 7'd0);
        send_request(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 7'd127);
        send_request(ACT_SPARE_HI, 16'hAAAA, 16'h5555, 7'd42);
        send_request(rfkr_pkg::ACT_DEQUEUE, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_CLEAR, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'hAAAA, 16'h5555, 7'd0);

        // fill to the default capacity, push past full, then clear the lot
        while (ledger.held_keys.size() < ledger.live_cap)
            send_request(rfkr_pkg::ACT_ENQUEUE, pooled_key(), rfkr_pkg::ID_W'($urandom),
                         rfkr_pkg::POS_W'($urandom_range(0, 127)));
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'hFFFF, 16'hFFFF, 7'd0);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'h0000, 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd64);
        send_request(rfkr_pkg::ACT_FIND, 16'h0000, 16'h0000, 7'd65);
        n = ledger.held_keys.size();
        send_request(rfkr_pkg::ACT_REMOVE, ledger.held_keys[n - 1], 16'h0000, 7'd0);
        send_request(rfkr_pkg::ACT_ENQUEUE, 16'h7777, 16'h8888, 7'd0);
        send_request(rfkr_pkg::ACT_CLEAR, 16'h0000, 16'h0000, 7'd0);
        random_run(15, 45, 5, 5);
        drain();

        write_register(rfkr_pkg::CFG_MAXIMUM, 7'd8);
        write_register(rfkr_pkg::CFG_INITIAL, 7'd3);
        random_run(25, 40, 20, 8);
        drain();

        calm = 1'b1;
        write_register(rfkr_pkg::CFG_MAXIMUM, 7'd0);
        write_register(rfkr_pkg::CFG_INITIAL, 7'd127);
        random_run(15, 35, 15, 10);
        drain();
        calm = 1'b0;

        write_register(rfkr_pkg::CFG_MAXIMUM, 7'd127);
        write_register(rfkr_pkg::CFG_INITIAL, 7'd0);
        random_run(15, 35, 25, 8);
        drain();

        // lower the maximum below the live capacity
        write_register(rfkr_pkg::CFG_INITIAL, 7'd10);
        write_register(rfkr_pkg::CFG_MAXIMUM, 7'd5);
        random_run(20, 45, 15, 8);
        drain();

        write_register(rfkr_pkg::CFG_MAXIMUM, 7'd64);
        write_register(rfkr_pkg::CFG_INITIAL, 7'd64);
        random_run(25, 40, 5, 6);

        in_valid <= 1'b0;
        waited = 0;
        while (ledger.due_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        $display("summary: %0d requests, %0d results, %0d register writes",
                 ledger.requests_seen, ledger.results_seen, cfg_writes);
        $display("summary: %0d full refusals, %0d keyed removals, %0d clears, %0d mismatches",
                 ledger.full_refusals, ledger.keyed_hits, ledger.clear_runs,
                 ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.due_results.size() == 0)
            $display("TB_OK");
        else
        begin
            if (ledger.due_results.size() != 0)
                $display("%0d expected results never arrived", ledger.due_results.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
